[design/ics_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_pkg
// Shared types and codes for the indexed character sequence store.
// ----------------------------------------------------------------------------
package ics_pkg;

    localparam int CHAR_W      = 8;
    localparam int POS_W       = 7;
    localparam int CNT_OUT_W   = 7;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [3:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_INSERT_AT  = 4'd2,
        CMD_INSERT_ORD = 4'd3,
        CMD_POP_FRONT  = 4'd4,
        CMD_POP_BACK   = 4'd5,
        CMD_REMOVE_AT  = 4'd6,
        CMD_REPLACE_AT = 4'd7,
        CMD_READ_AT    = 4'd8,
        CMD_CLEAR      = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_REM,
        S_SHIFT,
        S_PUT,
        S_RDCAP,
        S_TAIL0,
        S_TAIL1,
        S_TAIL2,
        S_DONE
    } state_t;

    // command word, last field in the low bits
    typedef struct packed {
        logic signed [CHAR_W-1:0] data_char;
        logic [POS_W-1:0]         position;
        logic [3:0]               cmd;
    } cmd_word_t;

    // result word, last field in the low bits
    typedef struct packed {
        logic                     is_empty;
        logic [CNT_OUT_W-1:0]     item_count;
        logic signed [CHAR_W-1:0] last_char;
        logic signed [CHAR_W-1:0] first_char;
        logic signed [CHAR_W-1:0] read_char;
        status_t                  status;
    } result_t;

endpackage

[design/indexed_char_sequence_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_char_sequence_store
// Ordered store of signed characters with push, pop, indexed and ordered
// insert, remove, replace, read and clear; one status word per command.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | tdata fields, low bit up
//  s_*      | in  | s_tvalid/s_tready  | cmd[3:0] position[10:4] data_char[18:11]
//  m_*      | out | m_tvalid/m_tready  | status[1:0] read_char[9:2] first_char[17:10]
//           |     |                    | last_char[25:18] item_count[32:26] is_empty[33]
//
//  One command at a time. Remove and insert move each following entry one slot
//  over. Ordered insert scans up to the split point, then shifts the entries
//  from there to the end; scan and shift share the single RAM read port.
//  Reset clears the count; character RAM contents are not cleared.
//  A finished word sits in the output register, so the next command is taken
//  while m_tready is low; the sequencer stalls only when its next word is ready
//  and the output register still holds a word that has not been taken.
// ----------------------------------------------------------------------------
module indexed_char_sequence_store #(
    parameter int MAX_LEN = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ics_pkg::IN_TDATA_W-1:0]     s_tdata,  // cmd, position, data_char
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ics_pkg::OUT_TDATA_W-1:0]    m_tdata   // status, read_char, first_char,
                                                         // last_char, item_count, is_empty
);

    localparam int CMD_BITS = $bits(ics_pkg::cmd_word_t);
    localparam int RES_BITS = $bits(ics_pkg::result_t);

    ics_pkg::cmd_word_t cmd_word;
    ics_pkg::result_t   res;
    logic               res_valid;
    logic               res_ready;

    ics_pkg::result_t   m_word_reg, m_word_next;
    logic               m_tvalid_reg, m_tvalid_next;

    assign cmd_word = ics_pkg::cmd_word_t'(s_tdata[CMD_BITS-1:0]);

    ics_seq #(
        .MAX_LEN (MAX_LEN)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd_in    (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_word_next   = m_word_reg;
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready)
        begin
            m_word_next   = res;
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_word_reg <= m_word_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(ics_pkg::OUT_TDATA_W - RES_BITS){1'b0}}, m_word_reg};

    // an empty store reports zero count and zero end characters
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_word_reg.is_empty) |->
        (m_word_reg.item_count == '0 && m_word_reg.first_char == '0 &&
         m_word_reg.last_char == '0))
        else $error("empty store with nonzero count or end chars");

    // pop from empty only happens on an empty store
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_word_reg.status == ics_pkg::ST_EMPTY) |->
        m_word_reg.is_empty)
        else $error("empty status on a non-empty store");

    // a taken command keeps the sequencer busy next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer took a second command back to back");

endmodule

[design/ics_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ics_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/ics_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_seq
// Command sequencer: decodes one command, scans and shifts the character RAM
// one entry per cycle, then reads back the first and last entries.
// ----------------------------------------------------------------------------
module ics_seq #(
    parameter int MAX_LEN = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  ics_pkg::cmd_word_t cmd_in,
    output logic              res_valid,
    input  logic              res_ready,
    output ics_pkg::result_t  res
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = (CW > ics_pkg::POS_W) ? CW : ics_pkg::POS_W;

    ics_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [AW-1:0]    prev_reg, prev_next;
    logic [AW-1:0]    lim_reg, lim_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             more_reg, more_next;
    logic             rv_reg, rv_next;
    logic             right_reg, right_next;
    logic [ics_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [ics_pkg::CHAR_W-1:0] rd_reg, rd_next;
    logic [ics_pkg::CHAR_W-1:0] first_reg, first_next;
    logic [ics_pkg::CHAR_W-1:0] last_reg, last_next;
    ics_pkg::status_t status_reg, status_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ics_pkg::CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [ics_pkg::CHAR_W-1:0] ram_rdata;

    logic          full;
    logic          is_zero;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic [AW-1:0] pos_addr;
    logic [AW-1:0] cnt_addr;
    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] cnt_inc;
    logic [AW-1:0] cnt_m1;

    ics_ram #(
        .WIDTH (ics_pkg::CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign full     = (count_reg == CW'(MAX_LEN));
    assign is_zero  = (count_reg == '0);
    assign pos_ext  = PW'(cmd_in.position);
    assign cnt_ext  = PW'(count_reg);
    assign pos_addr = pos_ext[AW-1:0];
    assign cnt_addr = count_reg[AW-1:0];
    assign cnt_dec  = count_reg - CW'(1);
    assign cnt_inc  = count_reg + CW'(1);
    assign cnt_m1   = cnt_dec[AW-1:0];

    assign cmd_ready = (state_reg == ics_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ics_pkg::S_IDLE;
            count_reg <= '0;
            more_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            more_reg  <= more_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        prev_reg   <= prev_next;
        lim_reg    <= lim_next;
        idx_reg    <= idx_next;
        right_reg  <= right_next;
        char_reg   <= char_next;
        rd_reg     <= rd_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        prev_next   = prev_reg;
        lim_next    = lim_reg;
        idx_next    = idx_reg;
        more_next   = more_reg;
        rv_next     = rv_reg;
        right_next  = right_reg;
        char_next   = char_reg;
        rd_next     = rd_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = char_reg;
        ram_raddr   = ptr_reg;
        res_valid   = 1'b0;

        unique case (state_reg)
            ics_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    status_next = ics_pkg::ST_OK;
                    rd_next     = '0;
                    char_next   = cmd_in.data_char;
                    state_next  = ics_pkg::S_TAIL0;
                    unique case (ics_pkg::cmd_t'(cmd_in.cmd))
                        ics_pkg::CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ics_pkg::ST_FULL;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ics_pkg::S_INS;
                            end
                        end
                        ics_pkg::CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ics_pkg::ST_FULL;
                            end
                            else
                            begin
                                idx_next   = cnt_addr;
                                state_next = ics_pkg::S_INS;
                            end
                        end
                        ics_pkg::CMD_INSERT_AT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                status_next = ics_pkg::ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ics_pkg::ST_FULL;
                            end
                            else
                            begin
                                idx_next   = pos_addr;
                                state_next = ics_pkg::S_INS;
                            end
                        end
                        ics_pkg::CMD_INSERT_ORD:
                        begin
                            if (full)
                            begin
                                status_next = ics_pkg::ST_FULL;
                            end
                            else if (is_zero)
                            begin
                                idx_next   = '0;
                                state_next = ics_pkg::S_INS;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                lim_next   = cnt_m1;
                                more_next  = 1'b1;
                                rv_next    = 1'b0;
                                state_next = ics_pkg::S_SCAN;
                            end
                        end
                        ics_pkg::CMD_POP_FRONT:
                        begin
                            if (is_zero)
                            begin
                                status_next = ics_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ics_pkg::S_REM;
                            end
                        end
                        ics_pkg::CMD_POP_BACK:
                        begin
                            if (is_zero)
                            begin
                                status_next = ics_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = cnt_dec;
                            end
                        end
                        ics_pkg::CMD_REMOVE_AT:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = ics_pkg::ST_RANGE;
                            end
                            else
                            begin
                                idx_next   = pos_addr;
                                state_next = ics_pkg::S_REM;
                            end
                        end
                        ics_pkg::CMD_REPLACE_AT:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = ics_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_addr;
                                ram_wdata = cmd_in.data_char;
                            end
                        end
                        ics_pkg::CMD_READ_AT:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = ics_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ram_raddr  = pos_addr;
                                state_next = ics_pkg::S_RDCAP;
                            end
                        end
                        ics_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ics_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // read ahead one entry; stop at the first entry not below the new char
            ics_pkg::S_SCAN:
            begin
                if (rv_reg && !($signed(char_reg) > $signed(ram_rdata)))
                begin
                    idx_next   = prev_reg;
                    rv_next    = 1'b0;
                    more_next  = 1'b0;
                    state_next = ics_pkg::S_INS;
                end
                else if (more_reg)
                begin
                    ram_raddr = ptr_reg;
                    prev_next = ptr_reg;
                    rv_next   = 1'b1;
                    if (ptr_reg == lim_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
                else
                begin
                    idx_next   = cnt_addr;
                    rv_next    = 1'b0;
                    state_next = ics_pkg::S_INS;
                end
            end

            ics_pkg::S_INS:
            begin
                if (idx_reg == cnt_addr)
                begin
                    state_next = ics_pkg::S_PUT;
                end
                else
                begin
                    ptr_next   = cnt_m1;
                    lim_next   = idx_reg;
                    more_next  = 1'b1;
                    rv_next    = 1'b0;
                    right_next = 1'b1;
                    state_next = ics_pkg::S_SHIFT;
                end
            end

            ics_pkg::S_REM:
            begin
                if (idx_reg == cnt_m1)
                begin
                    count_next = cnt_dec;
                    state_next = ics_pkg::S_TAIL0;
                end
                else
                begin
                    ptr_next   = idx_reg + AW'(1);
                    lim_next   = cnt_m1;
                    more_next  = 1'b1;
                    rv_next    = 1'b0;
                    right_next = 1'b0;
                    state_next = ics_pkg::S_SHIFT;
                end
            end

            // read one entry and write back the one read last cycle, one slot over
            ics_pkg::S_SHIFT:
            begin
                if (rv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = right_reg ? (prev_reg + AW'(1)) : (prev_reg - AW'(1));
                    ram_wdata = ram_rdata;
                end
                if (more_reg)
                begin
                    ram_raddr = ptr_reg;
                    prev_next = ptr_reg;
                    rv_next   = 1'b1;
                    if (ptr_reg == lim_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = right_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
                    end
                end
                else
                begin
                    rv_next = 1'b0;
                    if (right_reg)
                    begin
                        state_next = ics_pkg::S_PUT;
                    end
                    else
                    begin
                        count_next = cnt_dec;
                        state_next = ics_pkg::S_TAIL0;
                    end
                end
            end

            ics_pkg::S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = char_reg;
                count_next = cnt_inc;
                state_next = ics_pkg::S_TAIL0;
            end

            ics_pkg::S_RDCAP:
            begin
                rd_next    = ram_rdata;
                state_next = ics_pkg::S_TAIL0;
            end

            ics_pkg::S_TAIL0:
            begin
                if (is_zero)
                begin
                    first_next = '0;
                    last_next  = '0;
                    state_next = ics_pkg::S_DONE;
                end
                else
                begin
                    ram_raddr  = '0;
                    state_next = ics_pkg::S_TAIL1;
                end
            end

            ics_pkg::S_TAIL1:
            begin
                first_next = ram_rdata;
                ram_raddr  = cnt_m1;
                state_next = ics_pkg::S_TAIL2;
            end

            ics_pkg::S_TAIL2:
            begin
                last_next  = ram_rdata;
                state_next = ics_pkg::S_DONE;
            end

            ics_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ics_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ics_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status     = status_reg;
        res.read_char  = rd_reg;
        res.first_char = first_reg;
        res.last_char  = last_reg;
        res.item_count = ics_pkg::CNT_OUT_W'(count_reg);
        res.is_empty   = is_zero;
    end

endmodule
